// ===== sv/swcm_pkg.sv =====
package swcm_pkg;

   localparam int PAT_LEN = 24;
   localparam int SM_W    = 6;

   typedef enum logic [1:0] {
      REQ_FM_REF   = 2'd0,
      REQ_FM_FIRST = 2'd1,
      REQ_AM_REF   = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_kind_type;

   // Pattern bits shared by every request type
   localparam logic [PAT_LEN-1:0] HEAD_CARE  = 24'h60_427F;
   localparam logic [PAT_LEN-1:0] HEAD_WANT  = 24'h60_0226;
   // Reference id field, fixed zero at 12, and tail bit 23 (FM only)
   localparam logic [PAT_LEN-1:0] FM_CARE    = 24'h80_3C00;
   localparam logic [PAT_LEN-1:0] FM_WANT    = 24'h80_0000;
   // Zero run at 16..19 of the first-block pattern
   localparam logic [PAT_LEN-1:0] FIRST_CARE = 24'h0F_0000;

   typedef struct packed {
      logic [PAT_LEN-1:0] care;
      logic [PAT_LEN-1:0] want;
   } pattern_type;

   typedef struct packed {
      logic            kill;
      logic            first;
      logic [SM_W-1:0] sm;
   } side_type;

   function automatic pattern_type build_pattern(input logic [1:0] ref_id,
                                                 input logic [1:0] req_type);
      pattern_type p;
      p.care = HEAD_CARE;
      p.want = HEAD_WANT;
      case (req_type) inside
         REQ_FM_REF, REQ_FM_FIRST: begin
            p.care = p.care | FM_CARE;
            p.want = p.want | FM_WANT;
            p.want[10] = ref_id[1];
            p.want[11] = ref_id[0];
            p.want[13] = ref_id[1] ^ ref_id[0];
            if (req_type == REQ_FM_FIRST) begin
               p.care = p.care | FIRST_CARE;
            end
         end
         default: begin
         end
      endcase
      return p;
   endfunction

endpackage

// ===== sv/swcm_lane.sv =====
module swcm_lane #(
   parameter int BLOCK_LEN = 32,
   parameter int OFFSET    = 0
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [BLOCK_LEN-1:0]   data,
   input  swcm_pkg::pattern_type  pat,
   output logic                   hit
);

   logic [swcm_pkg::PAT_LEN-1:0] miss;
   logic                         hit_in;
   logic                         hit_ff;

   // Each pattern entry maps to a fixed data position for this offset
   for (genvar i = 0; i < swcm_pkg::PAT_LEN; i++) begin : g_bit
      localparam int POS = (OFFSET + i) % BLOCK_LEN;
      if (POS == 0) begin : g_skip
         assign miss[i] = 1'b0;
      end else begin : g_cmp
         assign miss[i] = pat.care[i] & (data[POS] ^ pat.want[i]);
      end
   end

   assign hit_in = ~|miss;

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

// ===== sv/swcm_merge.sv =====
module swcm_merge #(
   parameter int BLOCK_LEN = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [BLOCK_LEN-1:0]     hit,
   input  swcm_pkg::side_type       side,
   output logic                     rsp_valid,
   output logic                     found,
   output logic [4:0]               match_offset,
   output logic                     mode_valid,
   output logic [swcm_pkg::SM_W-1:0] service_mode
);

   localparam int GROUPS = (BLOCK_LEN + 7) / 8;
   localparam int GW     = $clog2(GROUPS);
   localparam int OW     = GW + 3;

   logic [GROUPS*8-1:0] padded;
   logic [GROUPS-1:0]   any_in;
   logic [2:0]          idx_in [GROUPS];
   logic [GROUPS-1:0]   any_ff;
   logic [2:0]          idx_ff [GROUPS];
   swcm_pkg::side_type  side_ff;
   logic                grp_valid_ff;

   logic [OW-1:0]            off;
   logic                     found_in;
   logic [4:0]               offset_in;
   logic                     mode_in;
   logic [swcm_pkg::SM_W-1:0] sm_in;

   logic                     rsp_valid_ff;
   logic                     found_ff;
   logic [4:0]               offset_ff;
   logic                     mode_ff;
   logic [swcm_pkg::SM_W-1:0] sm_ff;

   assign padded = (GROUPS*8)'(hit);

   // First hit within each group of eight offsets
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         any_in[g] = |padded[g*8 +: 8];
         idx_in[g] = 3'd0;
         for (int b = 7; b >= 0; b--) begin
            if (padded[g*8 + b]) begin
               idx_in[g] = 3'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
      end else if (advance) begin
         grp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         any_ff  <= any_in;
         idx_ff  <= idx_in;
         side_ff <= side;
      end
   end

   // First group with a hit gives the smallest offset
   always_comb begin
      off = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (any_ff[g]) begin
            off = {GW'(g), idx_ff[g]};
         end
      end
      found_in  = (|any_ff) & ~side_ff.kill;
      offset_in = found_in ? off[4:0] : 5'd0;
      mode_in   = found_in & side_ff.first & (off == '0);
      sm_in     = mode_in ? side_ff.sm : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= grp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         found_ff  <= found_in;
         offset_ff <= offset_in;
         mode_ff   <= mode_in;
         sm_ff     <= sm_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign found        = found_ff;
   assign match_offset = offset_ff;
   assign mode_valid   = mode_ff;
   assign service_mode = sm_ff;

   a_mode_needs_zero_hit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && mode_ff |-> found_ff && offset_ff == 5'd0)
      else $error("mode_valid without a match at offset zero");

   a_miss_zero_offset : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> offset_ff == 5'd0 && !mode_ff)
      else $error("offset or mode reported without a match");

   a_sm_only_when_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !mode_ff |-> sm_ff == '0)
      else $error("service mode set without mode_valid");

   a_kill_no_match : assert property (@(posedge clock) disable iff (reset)
      advance && grp_valid_ff && side_ff.kill |=> !found_ff)
      else $error("unused request type produced a match");

endmodule

// ===== sv/sync_word_cyclic_matcher.sv =====
// Channel  Ports                                           Direction
// req      req_valid/req_stall, sign_bits, ref_id, type    in
// rsp      rsp_valid/rsp_stall, found, offset, mode, sm    out
//
// One item per cycle while no stalled result holds the pipe; each item is registered at every stage.
// Stages: decode and pattern build, one lane per cyclic offset,
// per-group first hit over groups of eight offsets, group select.
// All stages move together; a stalled result holds the whole pipe and
// req_stall follows rsp_stall while the result register is full.
// Synchronous reset clears the valid bits only.
module sync_word_cyclic_matcher #(
   parameter int BLOCK_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sign_bits,
   input  logic [1:0]  req_ref_id,
   input  logic [1:0]  req_req_type,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [4:0]  rsp_match_offset,
   output logic        rsp_mode_valid,
   output logic [5:0]  rsp_service_mode
);

   logic                  advance;
   logic [BLOCK_LEN-1:0]  raw;
   logic [BLOCK_LEN-1:0]  data_in;
   swcm_pkg::side_type    side_in;

   logic                  s1_valid_ff;
   logic [BLOCK_LEN-1:0]  data_ff;
   swcm_pkg::pattern_type pat_ff;
   swcm_pkg::side_type    side1_ff;

   logic                  s2_valid_ff;
   swcm_pkg::side_type    side2_ff;
   logic [BLOCK_LEN-1:0]  hit;

   assign advance   = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~advance;

   assign raw = BLOCK_LEN'(req_sign_bits);

   // FM and unused types: differential decode with a zero bit before the block; AM uses raw bits
   always_comb begin
      if (req_req_type == swcm_pkg::REQ_AM_REF) begin
         data_in = raw;
      end else begin
         data_in = raw ^ (raw << 1);
      end
      side_in.kill  = (req_req_type == swcm_pkg::REQ_UNUSED);
      side_in.first = (req_req_type == swcm_pkg::REQ_FM_FIRST);
      side_in.sm    = {data_in[25], data_in[26], data_in[27],
                       data_in[28], data_in[29], data_in[30]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff  <= data_in;
         pat_ff   <= swcm_pkg::build_pattern(req_ref_id, req_req_type);
         side1_ff <= side_in;
         side2_ff <= side1_ff;
      end
   end

   for (genvar n = 0; n < BLOCK_LEN; n++) begin : g_lane
      swcm_lane #(
         .BLOCK_LEN (BLOCK_LEN),
         .OFFSET    (n)
      ) u_lane (
         .clock   (clock),
         .advance (advance),
         .data    (data_ff),
         .pat     (pat_ff),
         .hit     (hit[n])
      );
   end

   swcm_merge #(
      .BLOCK_LEN (BLOCK_LEN)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (s2_valid_ff),
      .hit          (hit),
      .side         (side2_ff),
      .rsp_valid    (rsp_valid),
      .found        (rsp_found),
      .match_offset (rsp_match_offset),
      .mode_valid   (rsp_mode_valid),
      .service_mode (rsp_service_mode)
   );

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import swcm_pkg::*;

   localparam int BLOCK_LEN      = 32;
   localparam int NUM_DIRECTED   = 21;
   localparam int RAND_PER_PHASE = 534;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic       found;
      logic [4:0] match_off;
      logic       mode_valid;
      logic [5:0] service_mode;
   } sync_result_t;

   typedef struct packed {
      logic [23:0] care;
      logic [23:0] want;
      logic [4:0]  plen;
   } sync_pat_t;

   typedef struct packed {
      logic         raw;
      logic [31:0]  word;
      logic [1:0]   ref_id;
      req_kind_type kind;
      logic [4:0]   rot;
      logic         typed;
      sync_result_t result;
   } stim_row_t;

   localparam sync_result_t NO_MATCH = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_sign_bits = '0;
   logic [1:0]  req_ref_id = '0;
   logic [1:0]  req_req_type = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [4:0]  rsp_match_offset;
   logic        rsp_mode_valid;
   logic [5:0]  rsp_service_mode;

   sync_result_t pending_results[$];
   int           mismatch_cnt = 0;
   int           cycle_cnt = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   sync_word_cyclic_matcher #(
      .BLOCK_LEN(BLOCK_LEN)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sign_bits(req_sign_bits),
      .req_ref_id(req_ref_id),
      .req_req_type(req_req_type),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_match_offset(rsp_match_offset),
      .rsp_mode_valid(rsp_mode_valid),
      .rsp_service_mode(rsp_service_mode)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Sync word with don't cares; AM drops the reference id field and the tail bit
   function automatic sync_pat_t build_sync_pattern(logic [1:0] rid, req_kind_type kind);
      sync_pat_t pat;
      pat.care = 24'h00_027F;
      pat.want = 24'h00_0226;
      pat.care[14] = 1'b1;
      pat.care[21] = 1'b1;
      pat.care[22] = 1'b1;
      pat.want[21] = 1'b1;
      pat.want[22] = 1'b1;
      if (kind == REQ_AM_REF) begin
         pat.plen = 5'd23;
      end else begin
         pat.plen = 5'd24;
         pat.care[13:10] = 4'hF;
         pat.want[10] = rid[1];
         pat.want[11] = rid[0];
         pat.want[13] = rid[1] ^ rid[0];
         pat.care[23] = 1'b1;
         pat.want[23] = 1'b1;
         if (kind == REQ_FM_FIRST) begin
            pat.care[19:16] = 4'hF;
         end
      end
      return pat;
   endfunction

   function automatic sync_result_t predict_sync_match(logic [31:0] sign, logic [1:0] rid,
                                                       req_kind_type kind);
      sync_result_t res;
      sync_pat_t    pat;
      logic [31:0]  data;
      logic         ok;
      int           pos;
      res = NO_MATCH;
      if (kind == REQ_UNUSED) begin
         return res;
      end
      pat = build_sync_pattern(rid, kind);
      data = (kind == REQ_AM_REF) ? sign : (sign ^ (sign << 1));
      for (int n = 0; n < BLOCK_LEN && !res.found; n++) begin
         ok = 1'b1;
         for (int i = 0; i < pat.plen; i++) begin
            pos = (n + i) % BLOCK_LEN;
            // data position 0 has no reference and is never compared
            if (pos != 0 && pat.care[i] && data[pos] != pat.want[i]) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            res.found = 1'b1;
            res.match_off = 5'(n);
         end
      end
      if (res.found && kind == REQ_FM_FIRST && res.match_off == 5'd0) begin
         res.mode_valid = 1'b1;
         for (int p = 25; p <= 30; p++) begin
            res.service_mode = {res.service_mode[4:0], data[p]};
         end
      end
      return res;
   endfunction

   function automatic logic [31:0] dbpsk_encode(logic [31:0] d);
      logic [31:0] b;
      logic        prev;
      prev = 1'b0;
      for (int n = 0; n < 32; n++) begin
         b[n] = d[n] ^ prev;
         prev = b[n];
      end
      return b;
   endfunction

   // Words are in the decoded domain unless raw; FM rows get encoded before sending
   function automatic stim_row_t directed_row(int idx);
      stim_row_t row;
      row = '0;
      case (idx)
         0:  row = '{1'b1, 32'h0000_0000, 2'd0, REQ_FM_REF,   5'd0,  1'b1, NO_MATCH};
         1:  row = '{1'b1, 32'h0000_0000, 2'd1, REQ_FM_FIRST, 5'd0,  1'b1, NO_MATCH};
         2:  row = '{1'b1, 32'h0000_0000, 2'd2, REQ_AM_REF,   5'd0,  1'b1, NO_MATCH};
         3:  row = '{1'b1, 32'h0000_0000, 2'd3, REQ_UNUSED,   5'd0,  1'b1, NO_MATCH};
         4:  row = '{1'b1, 32'hFFFF_FFFF, 2'd3, REQ_FM_REF,   5'd0,  1'b1, NO_MATCH};
         5:  row = '{1'b1, 32'hFFFF_FFFF, 2'd3, REQ_FM_FIRST, 5'd0,  1'b1, NO_MATCH};
         6:  row = '{1'b1, 32'hFFFF_FFFF, 2'd3, REQ_AM_REF,   5'd0,  1'b1, NO_MATCH};
         7:  row = '{1'b1, 32'hFFFF_FFFF, 2'd0, REQ_UNUSED,   5'd0,  1'b1, NO_MATCH};
         8:  row = '{1'b0, 32'h00E0_0226, 2'd0, REQ_FM_REF,   5'd0,  1'b0, NO_MATCH};
         9:  row = '{1'b0, 32'h00E0_2A26, 2'd1, REQ_FM_REF,   5'd0,  1'b0, NO_MATCH};
         10: row = '{1'b0, 32'h00E0_2626, 2'd2, REQ_FM_REF,   5'd0,  1'b0, NO_MATCH};
         11: row = '{1'b0, 32'h00E0_0E26, 2'd3, REQ_FM_REF,   5'd0,  1'b0, NO_MATCH};
         // first block at offset zero, all-ones and alternating service mode, then at a nonzero offset
         12: row = '{1'b0, 32'h7EE0_2626, 2'd2, REQ_FM_FIRST, 5'd0,  1'b0, NO_MATCH};
         13: row = '{1'b0, 32'h2AE0_2A26, 2'd1, REQ_FM_FIRST, 5'd0,  1'b0, NO_MATCH};
         14: row = '{1'b0, 32'h00E0_0226, 2'd0, REQ_FM_FIRST, 5'd7,  1'b0, NO_MATCH};
         // zero run of the first block broken
         15: row = '{1'b0, 32'h00E2_0226, 2'd0, REQ_FM_FIRST, 5'd0,  1'b0, NO_MATCH};
         16: row = '{1'b0, 32'h0060_0226, 2'd1, REQ_AM_REF,   5'd0,  1'b0, NO_MATCH};
         // pattern wraps past the end of the block
         17: row = '{1'b0, 32'h0060_0226, 2'd2, REQ_AM_REF,   5'd20, 1'b0, NO_MATCH};
         18: row = '{1'b0, 32'h00E0_0E26, 2'd3, REQ_FM_REF,   5'd31, 1'b0, NO_MATCH};
         // sync word of another reference id
         19: row = '{1'b0, 32'h00E0_0E26, 2'd0, REQ_FM_REF,   5'd0,  1'b0, NO_MATCH};
         20: row = '{1'b0, 32'h00E0_0226, 2'd0, REQ_UNUSED,   5'd0,  1'b1, NO_MATCH};
         default: row = '0;
      endcase
      return row;
   endfunction

   task automatic offer_item(logic [31:0] sign, logic [1:0] rid, req_kind_type kind,
                             logic typed, sync_result_t typed_res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sign_bits <= sign;
      req_ref_id    <= rid;
      req_req_type  <= kind;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_results.push_back(typed ? typed_res : predict_sync_match(sign, rid, kind));
   endtask

   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      sync_result_t exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected");
            mismatch_cnt++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_found !== exp_res.found) begin
               $error("found: expected %0d, got %0d", exp_res.found, rsp_found);
               mismatch_cnt++;
            end
            if (rsp_match_offset !== exp_res.match_off) begin
               $error("match_offset: expected %0d, got %0d", exp_res.match_off,
                      rsp_match_offset);
               mismatch_cnt++;
            end
            if (rsp_mode_valid !== exp_res.mode_valid) begin
               $error("mode_valid: expected %0d, got %0d", exp_res.mode_valid,
                      rsp_mode_valid);
               mismatch_cnt++;
            end
            if (rsp_service_mode !== exp_res.service_mode) begin
               $error("service_mode: expected %0d, got %0d", exp_res.service_mode,
                      rsp_service_mode);
               mismatch_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      stim_row_t    row;
      sync_pat_t    pat;
      logic [31:0]  word;
      logic [1:0]   rid;
      req_kind_type kind;
      int           off;
      int           brk_idx;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct  = 27;
               recv_stall_pct <= 46;
            end
            1: begin
               send_idle_pct  = 46;
               recv_stall_pct <= 27;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct <= 0;
            end
         endcase
         if (ph == 0) begin
            for (int k = 0; k < NUM_DIRECTED; k++) begin
               row = directed_row(k);
               word = (row.word << row.rot) | (row.word >> (6'd32 - row.rot));
               if (!row.raw && row.kind != REQ_AM_REF) begin
                  word = dbpsk_encode(word);
               end
               offer_item(word, row.ref_id, row.kind, row.typed, row.result);
            end
         end
         for (int k = 0; k < RAND_PER_PHASE; k++) begin
            rid = 2'($urandom_range(3));
            kind = ($urandom_range(99) < 5) ? REQ_UNUSED : req_kind_type'($urandom_range(2));
            if ($urandom_range(99) < 70) begin
               // plant the sync word at a random offset, now and then with one bit wrong
               pat = build_sync_pattern(rid, kind);
               off = (kind == REQ_FM_FIRST && $urandom_range(99) < 40) ? 0 :
                     $urandom_range(BLOCK_LEN - 1);
               word = $urandom();
               for (int i = 0; i < pat.plen; i++) begin
                  if (pat.care[i]) begin
                     word[(off + i) % BLOCK_LEN] = pat.want[i];
                  end
               end
               if ($urandom_range(99) < 20) begin
                  do begin
                     brk_idx = $urandom_range(pat.plen - 1);
                  end while (!pat.care[brk_idx]);
                  word[(off + brk_idx) % BLOCK_LEN] = ~word[(off + brk_idx) % BLOCK_LEN];
               end
               if (kind != REQ_AM_REF) begin
                  word = dbpsk_encode(word);
               end
            end else begin
               word = $urandom();
            end
            offer_item(word, rid, kind, 1'b0, NO_MATCH);
         end
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sync_word_cyclic_matcher.f =====
sv/swcm_pkg.sv
sv/swcm_lane.sv
sv/swcm_merge.sv
sv/sync_word_cyclic_matcher.sv
tb/testbench.sv
